// ===== sv/hpid_pkg.sv =====
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared types and constants of the heading PID controller.
// ----------------------------------------------------------------------------
package hpid_pkg;

	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam int OP_W     = 2;
	localparam int ANGLE_W  = 16;
	localparam int GAIN_W   = 16;
	localparam int LIMIT_W  = 31;
	localparam int DRIVE_W  = 32;
	localparam int ERR_W    = 16;
	localparam int DERIV_W  = 17;
	localparam int SUM_W    = 32;
	localparam int MAG_W    = 15;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 31;

	// angles in centidegrees
	localparam int WRAP_W = 18;
	localparam logic [WRAP_W-1:0] FULL_TURN = WRAP_W'(360 * 100);
	localparam logic [WRAP_W-1:0] HALF_TURN = WRAP_W'(180 * 100);

	typedef enum logic [OP_W-1:0] {
		OP_HEADING  = 2'd0,
		OP_SETPOINT = 2'd1,
		OP_TICK     = 2'd2
	} op_t;

	localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RESET_THR   = 3'd4;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd256;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd0;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 16'd0;
	localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 31'd100000;
	localparam logic [LIMIT_W-1:0] RESET_THR_RST   = 31'd10000;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [LIMIT_W-1:0] integ_limit;
		logic [LIMIT_W-1:0] reset_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [DERIV_W-1:0] deriv;
		logic signed [SUM_W-1:0]   integ;
	} tick_t;

endpackage

// ===== sv/hpid_if.sv =====
// ----------------------------------------------------------------------------
// hpid_cmd_if / hpid_rsp_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface hpid_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [hpid_pkg::OP_W-1:0]      operation;
	logic [hpid_pkg::ANGLE_W-1:0]   angle;

	modport source (output valid, output operation, output angle, input ready);
	modport sink   (input valid, input operation, input angle, output ready);
endinterface

interface hpid_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [hpid_pkg::DRIVE_W-1:0] drive;
	logic signed [hpid_pkg::ERR_W-1:0]   heading_error;

	modport source (output valid, output drive, output heading_error, input ready);
	modport sink   (input valid, input drive, input heading_error, output ready);
endinterface

// ===== sv/hpid_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hpid_cfg_regs
// Gain, limit and threshold registers behind the write port.
// ----------------------------------------------------------------------------
module hpid_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [hpid_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [hpid_pkg::CFG_DATA_W-1:0]     cfg_data,
	output hpid_pkg::cfg_t                      cfg
);

	hpid_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= hpid_pkg::PROP_GAIN_RST;
			cfg_q.deriv_gain      <= hpid_pkg::DERIV_GAIN_RST;
			cfg_q.integ_gain      <= hpid_pkg::INTEG_GAIN_RST;
			cfg_q.integ_limit     <= hpid_pkg::INTEG_LIMIT_RST;
			cfg_q.reset_threshold <= hpid_pkg::RESET_THR_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				hpid_pkg::REG_PROP_GAIN:   cfg_q.prop_gain  <= cfg_data[hpid_pkg::GAIN_W-1:0];
				hpid_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain <= cfg_data[hpid_pkg::GAIN_W-1:0];
				hpid_pkg::REG_INTEG_GAIN:  cfg_q.integ_gain <= cfg_data[hpid_pkg::GAIN_W-1:0];
				hpid_pkg::REG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_data[hpid_pkg::LIMIT_W-1:0];
				hpid_pkg::REG_RESET_THR:   cfg_q.reset_threshold <= cfg_data[hpid_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/hpid_update.sv =====
// ----------------------------------------------------------------------------
// hpid_update
// Command register, heading state, wrapped error, derivative and clamped
// integral. Hands tick terms to the summing stage.
// ----------------------------------------------------------------------------
module hpid_update #(
	parameter int GAIN_FRAC_BITS = hpid_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hpid_cmd_if.sink              cmd,
	input  hpid_pkg::cfg_t        cfg,
	output logic                  valid_s2,
	output hpid_pkg::tick_t       tick_s2,
	input  logic                  s2_ready
);

	localparam int WRAP_W = hpid_pkg::WRAP_W;
	localparam logic [WRAP_W-1:0] TWO_TURNS   = WRAP_W'(hpid_pkg::FULL_TURN * 2);
	localparam logic [WRAP_W-1:0] THREE_TURNS = WRAP_W'(hpid_pkg::FULL_TURN * 3);

	logic                           valid_s1;
	logic [hpid_pkg::OP_W-1:0]      op_s1;
	logic [hpid_pkg::ANGLE_W-1:0]   angle_s1;

	logic [hpid_pkg::ANGLE_W-1:0]   target_q;
	logic [hpid_pkg::ANGLE_W-1:0]   measured_q;
	logic signed [hpid_pkg::ERR_W-1:0] last_err_q;
	logic signed [hpid_pkg::SUM_W-1:0] err_sum_q;
	logic                           first_q;

	logic                           s2_free;
	logic                           is_tick;
	logic                           adv_s1;

	logic [WRAP_W-1:0]              wrap_sum;
	logic [WRAP_W-1:0]              wrap_rem;
	logic signed [hpid_pkg::ERR_W-1:0] err;
	logic [hpid_pkg::ERR_W-1:0]     err_abs;
	logic [hpid_pkg::MAG_W-1:0]     err_mag;
	logic [hpid_pkg::LIMIT_W-1:0]   p_prod;
	logic [hpid_pkg::LIMIT_W-1:0]   p_level;
	logic                           clear;
	logic signed [hpid_pkg::DERIV_W-1:0] deriv_raw;
	logic signed [hpid_pkg::SUM_W:0]     sum_raw;
	logic signed [hpid_pkg::SUM_W:0]     lim;
	logic signed [hpid_pkg::SUM_W-1:0]   sum_clamp;
	hpid_pkg::tick_t                tick;

	assign s2_free   = !valid_s2 || s2_ready;
	assign is_tick   = (op_s1 == hpid_pkg::OP_TICK);
	assign adv_s1    = valid_s1 && (!is_tick || s2_free);
	assign cmd.ready = !valid_s1 || adv_s1;

	// error = ((target - measured) mod full turn) - half turn
	always_comb begin
		wrap_sum = {2'b00, target_q} - {2'b00, measured_q} + TWO_TURNS;
		if (wrap_sum >= THREE_TURNS)
			wrap_rem = wrap_sum - THREE_TURNS;
		else if (wrap_sum >= TWO_TURNS)
			wrap_rem = wrap_sum - TWO_TURNS;
		else if (wrap_sum >= hpid_pkg::FULL_TURN)
			wrap_rem = wrap_sum - hpid_pkg::FULL_TURN;
		else
			wrap_rem = wrap_sum;
		err = signed'(wrap_rem[hpid_pkg::ERR_W-1:0] - hpid_pkg::HALF_TURN[hpid_pkg::ERR_W-1:0]);
	end

	always_comb begin
		err_abs = err[hpid_pkg::ERR_W-1] ? hpid_pkg::ERR_W'(-err) : hpid_pkg::ERR_W'(err);
		err_mag = err_abs[hpid_pkg::MAG_W-1:0];
		p_prod  = hpid_pkg::LIMIT_W'(cfg.prop_gain * err_mag);
		p_level = p_prod >> GAIN_FRAC_BITS;
		clear   = (p_level >= cfg.reset_threshold);

		if (first_q) begin
			deriv_raw = '0;
			sum_raw   = (hpid_pkg::SUM_W+1)'(err);
		end else begin
			deriv_raw = hpid_pkg::DERIV_W'(err) - hpid_pkg::DERIV_W'(last_err_q);
			sum_raw   = (hpid_pkg::SUM_W+1)'(err_sum_q) + (hpid_pkg::SUM_W+1)'(err);
		end

		lim = signed'({2'b00, cfg.integ_limit});
		if (sum_raw > lim)
			sum_clamp = hpid_pkg::SUM_W'(lim);
		else if (sum_raw < -lim)
			sum_clamp = hpid_pkg::SUM_W'(-lim);
		else
			sum_clamp = hpid_pkg::SUM_W'(sum_raw);

		tick.err   = err;
		tick.deriv = clear ? '0 : deriv_raw;
		tick.integ = clear ? '0 : sum_clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1    <= cmd.operation;
			angle_s1 <= cmd.angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			measured_q <= '0;
			last_err_q <= '0;
			err_sum_q  <= '0;
			first_q    <= 1'b1;
		end else if (adv_s1) begin
			case (op_s1)
				hpid_pkg::OP_HEADING: begin
					measured_q <= angle_s1;
				end
				hpid_pkg::OP_SETPOINT: begin
					target_q   <= angle_s1;
					last_err_q <= '0;
					err_sum_q  <= '0;
					first_q    <= 1'b0;
				end
				hpid_pkg::OP_TICK: begin
					last_err_q <= tick.err;
					err_sum_q  <= tick.integ;
					first_q    <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv_s1 && is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_tick) begin
			tick_s2 <= tick;
		end
	end

endmodule

// ===== sv/hpid_sum.sv =====
// ----------------------------------------------------------------------------
// hpid_sum
// Weighted sum of the three terms, floor shift, saturation and the result
// register.
// ----------------------------------------------------------------------------
module hpid_sum #(
	parameter int GAIN_FRAC_BITS = hpid_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hpid_pkg::cfg_t   cfg,
	input  logic             valid_s2,
	input  hpid_pkg::tick_t  tick_s2,
	output logic             s2_ready,
	hpid_rsp_if.source       rsp
);

	localparam int ACC_W = 52;
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

	logic signed [32:0]      prod_p;
	logic signed [33:0]      prod_d;
	logic signed [48:0]      prod_i;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [hpid_pkg::DRIVE_W-1:0] drive;

	logic                                valid_q;
	logic signed [hpid_pkg::DRIVE_W-1:0] drive_q;
	logic signed [hpid_pkg::ERR_W-1:0]   err_q;

	assign s2_ready = !valid_q || rsp.ready;

	always_comb begin
		prod_p = signed'({1'b0, cfg.prop_gain})  * tick_s2.err;
		prod_d = signed'({1'b0, cfg.deriv_gain}) * tick_s2.deriv;
		prod_i = signed'({1'b0, cfg.integ_gain}) * tick_s2.integ;
		acc    = ACC_W'(prod_p) + ACC_W'(prod_d) + ACC_W'(prod_i);
		acc_sh = acc >>> GAIN_FRAC_BITS;
		if (acc_sh > SAT_MAX)
			drive = hpid_pkg::DRIVE_W'(SAT_MAX);
		else if (acc_sh < SAT_MIN)
			drive = hpid_pkg::DRIVE_W'(SAT_MIN);
		else
			drive = hpid_pkg::DRIVE_W'(acc_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s2_ready) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s2) begin
			drive_q <= drive;
			err_q   <= tick_s2.err;
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.drive         = drive_q;
	assign rsp.heading_error = err_q;

endmodule

// ===== sv/heading_pid_controller.sv =====
// ----------------------------------------------------------------------------
// heading_pid_controller
// Fixed-point heading PID with integral clamp and integral/derivative reset.
// Throughput: one command beat per cycle while no tick beat waits on a full
// term register. Heading and setpoint beats give no result; a tick beat's
// result passes the command register, term register and result register.
// Reset: registers to defaults, headings and integral cleared, first pass set.
// ----------------------------------------------------------------------------
module heading_pid_controller #(
	parameter int GAIN_FRAC_BITS = hpid_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hpid_cmd_if.sink                         cmd,
	hpid_rsp_if.source                       rsp,
	input  logic                             cfg_wen,
	input  logic [hpid_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hpid_pkg::CFG_DATA_W-1:0]  cfg_data
);

	hpid_pkg::cfg_t  cfg;
	logic            valid_s2;
	hpid_pkg::tick_t tick_s2;
	logic            s2_ready;

	hpid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hpid_update #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.tick_s2  (tick_s2),
		.s2_ready (s2_ready)
	);

	hpid_sum #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.tick_s2  (tick_s2),
		.s2_ready (s2_ready),
		.rsp      (rsp)
	);

endmodule
